// ===== hdl/qce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qce_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int THR_W    = 16;
    localparam int SCALE_W  = 16;
    localparam int TIME_W   = 32;
    localparam int WRAP_W   = 32;
    localparam int POS_W    = 48;
    localparam int DIFF_W   = POS_W + 1;
    localparam int DIVR_W   = TIME_W + 1;
    localparam int PROD_W   = POS_W + SCALE_W + 1;
    localparam int SCALE_FRAC = 14;

    // Sample jump compare: room for any COUNT_BITS up to 32 and the threshold
    localparam int CMP_W = 34;

    localparam int DIV_STEPS = POS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_POSITION_SCALE = CFG_INDEX_W'(1);

    localparam logic [THR_W-1:0]   WRAP_THRESHOLD_RESET = THR_W'(25000);
    localparam logic [SCALE_W-1:0] POSITION_SCALE_RESET = SCALE_W'(16384);

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // One queued job: new position, previous position, elapsed ticks
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] prev_pos;
        logic [TIME_W-1:0]       elapsed;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PREP = 4'b0010,
        B_DIV  = 4'b0100,
        B_DONE = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/qce_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qce_front
    import qce_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [COUNT_BITS-1:0] count_sample,
    input  wire logic [TIME_W-1:0]     sample_time,
    input  wire logic [THR_W-1:0]      wrap_threshold,
    input  wire logic                  q_full,
    output logic                       q_push,
    output job_t                       q_entry
);

    localparam logic signed [63:0] WRAP_HI = (64'sd1 <<< (47 - COUNT_BITS)) - 64'sd1;
    localparam logic signed [63:0] WRAP_LO = -(64'sd1 <<< (47 - COUNT_BITS));

    logic                    s1_valid_reg, s1_valid_next;
    logic [COUNT_BITS-1:0]   s1_sample_reg;
    logic [TIME_W-1:0]       s1_elapsed_reg;
    logic [COUNT_BITS-1:0]   last_count_reg;
    logic [WRAP_W-1:0]       wrap_count_reg, wrap_count_next;
    logic [TIME_W-1:0]       last_time_reg;
    logic signed [POS_W-1:0] last_position_reg;

    logic                    accept;
    logic signed [CMP_W-1:0] prev_ext, cur_ext, thr_ext;
    logic signed [63:0]      wraps_ext;
    logic signed [POS_W-1:0] pos;

    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = s1_valid_reg && !q_full;

    always_comb
    begin
        prev_ext = $signed(CMP_W'(last_count_reg));
        cur_ext  = $signed(CMP_W'(count_sample));
        thr_ext  = $signed(CMP_W'(wrap_threshold));
        wrap_count_next = wrap_count_reg;
        // the two wrap directions exclude each other since the threshold is never negative
        priority if (prev_ext - cur_ext > thr_ext)
        begin
            wrap_count_next = wrap_count_reg + WRAP_W'(1);
        end
        else if (cur_ext - prev_ext > thr_ext)
        begin
            wrap_count_next = wrap_count_reg - WRAP_W'(1);
        end
        else
        begin
            wrap_count_next = wrap_count_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    // Low COUNT_BITS of the position are the sample itself; clamp on wrap count range
    always_comb
    begin
        wraps_ext = {{(64-WRAP_W){wrap_count_reg[WRAP_W-1]}}, wrap_count_reg};
        priority if (wraps_ext > WRAP_HI)
        begin
            pos = POS_MAX;
        end
        else if (wraps_ext < WRAP_LO)
        begin
            pos = POS_MIN;
        end
        else
        begin
            pos = {wraps_ext[POS_W-1-COUNT_BITS:0], s1_sample_reg};
        end
    end

    always_comb
    begin
        q_entry.pos      = pos;
        q_entry.prev_pos = last_position_reg;
        q_entry.elapsed  = s1_elapsed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            last_count_reg    <= '0;
            wrap_count_reg    <= '0;
            last_time_reg     <= '0;
            last_position_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                last_count_reg <= count_sample;
                wrap_count_reg <= wrap_count_next;
                last_time_reg  <= sample_time;
            end
            if (q_push)
            begin
                last_position_reg <= pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg  <= count_sample;
            s1_elapsed_reg <= sample_time - last_time_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qce_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qce_queue
    import qce_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_entry,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head
);

    job_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/qce_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qce_back
    import qce_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire job_t           q_head,
    output logic                q_pop,
    input  wire logic [SCALE_W-1:0] position_scale,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic signed [POS_W-1:0] scaled_position,
    output logic signed [POS_W-1:0] velocity
);

    back_state_t              state_reg, state_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [DIVR_W-1:0]        div_reg;
    logic signed [POS_W-1:0]  scaled_reg, scaled_next;
    logic [POS_W-1:0]         num_reg, num_next;
    logic [DIVR_W:0]          rem_reg, rem_next;
    logic                     neg_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0]  scaled_out_reg, vel_out_reg;
    logic signed [POS_W-1:0]  vel_next;

    logic                     out_free, load_out;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    logic signed [DIFF_W-1:0] diff_abs;
    logic [DIVR_W:0]          trial;

    assign out_free        = !out_valid_reg || !out_stall;
    assign load_out        = (state_reg == B_DONE) && out_free;
    assign q_pop           = (state_reg == B_IDLE) && q_valid;
    assign out_valid       = out_valid_reg;
    assign scaled_position = scaled_out_reg;
    assign velocity        = vel_out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_PREP;
                end
            end
            B_PREP:
            begin
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Truncate toward zero: bias negative products before the arithmetic shift
    always_comb
    begin
        biased  = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'((1 << SCALE_FRAC) - 1) : '0);
        shifted = biased >>> SCALE_FRAC;
        priority if (shifted > $signed(PROD_W'(POS_MAX)))
        begin
            scaled_next = POS_MAX;
        end
        else if (shifted < -$signed(PROD_W'(POS_MAX)) - PROD_W'(1))
        begin
            scaled_next = POS_MIN;
        end
        else
        begin
            scaled_next = shifted[POS_W-1:0];
        end
        diff_abs = diff_reg[DIFF_W-1] ? -diff_reg : diff_reg;
    end

    // Restoring divide, one quotient bit per cycle shifted into num_reg
    always_comb
    begin
        trial    = {rem_reg[DIVR_W-1:0], num_reg[POS_W-1]};
        rem_next = trial;
        num_next = {num_reg[POS_W-2:0], 1'b0};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = trial - {1'b0, div_reg};
            num_next = {num_reg[POS_W-2:0], 1'b1};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            vel_next = (num_reg[POS_W-1] && |num_reg[POS_W-2:0]) ? POS_MIN
                       : -$signed(num_reg);
        end
        else
        begin
            vel_next = num_reg[POS_W-1] ? POS_MAX : $signed(num_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                prod_reg <= PROD_W'(q_head.pos) * PROD_W'($signed({1'b0, position_scale}));
                diff_reg <= DIFF_W'(q_head.pos) - DIFF_W'(q_head.prev_pos);
                div_reg  <= DIVR_W'(q_head.elapsed) + DIVR_W'(1);
            end
            B_PREP:
            begin
                scaled_reg <= scaled_next;
                neg_reg    <= diff_reg[DIFF_W-1];
                num_reg    <= diff_abs[POS_W-1:0];
                rem_reg    <= '0;
                step_reg   <= '0;
            end
            B_DIV:
            begin
                num_reg  <= num_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + STEP_W'(1);
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    scaled_out_reg <= scaled_reg;
                    vel_out_reg    <= vel_next;
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/quadrature_count_extender.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path from input transfer to result valid: front stage, queue, prep, 48-step divide.
// The back end takes a new item only after its one-bit-per-cycle velocity divider has finished the last one.
// The front end and a two-entry queue take up to three further items while the divider runs.
// Reset (rst_n, asynchronous, active low): position history and wrap count cleared, queue
// emptied, registers to threshold 25000 and scale 16384; no clearing pass, ready at once.

module quadrature_count_extender
    import qce_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [COUNT_BITS-1:0]   count_sample,
    input  wire logic [TIME_W-1:0]       sample_time,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [POS_W-1:0]      scaled_position,
    output logic signed [POS_W-1:0]      velocity,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    logic [THR_W-1:0]   wrap_threshold_reg;
    logic [SCALE_W-1:0] position_scale_reg;

    logic q_full, q_push, q_pop, q_valid;
    job_t q_entry, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_threshold_reg <= WRAP_THRESHOLD_RESET;
            position_scale_reg <= POSITION_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WRAP_THRESHOLD: wrap_threshold_reg <= cfg_data[THR_W-1:0];
                REG_POSITION_SCALE: position_scale_reg <= cfg_data[SCALE_W-1:0];
                default:
                begin
                    // drop writes to unmapped indexes
                    wrap_threshold_reg <= wrap_threshold_reg;
                end
            endcase
        end
    end

    qce_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .count_sample   (count_sample),
        .sample_time    (sample_time),
        .wrap_threshold (wrap_threshold_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    qce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    qce_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .position_scale  (position_scale_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .scaled_position (scaled_position),
        .velocity        (velocity)
    );

endmodule

`default_nettype wire

// ===== tb/tb_quadrature_count_extender.sv =====
`timescale 1ns / 1ps

module tb_quadrature_count_extender;
    import qce_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 60;
    localparam int RAND_PER_SET = 180;

    typedef struct {
        logic signed [POS_W-1:0] sp;
        logic signed [POS_W-1:0] vel;
    } motion_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    // ROW_ITEM: a = count, b = time; ROW_CFG: a = register index, b = data
    typedef struct {
        row_kind_t               kind;
        logic [31:0]             a;
        logic [31:0]             b;
        bit                      typed;
        logic signed [POS_W-1:0] sp;
        logic signed [POS_W-1:0] vel;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [15:0]            count_sample;
    logic [TIME_W-1:0]      sample_time;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [POS_W-1:0] scaled_position;
    logic signed [POS_W-1:0] velocity;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    quadrature_count_extender u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .count_sample   (count_sample),
        .sample_time    (sample_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scaled_position(scaled_position),
        .velocity       (velocity),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Mirror of the block's state and registers
    logic [15:0]        mir_count = '0;
    int                 mir_wraps = 0;
    longint             mir_pos   = 0;
    logic [TIME_W-1:0]  mir_time  = '0;
    logic [THR_W-1:0]   mir_thr   = WRAP_THRESHOLD_RESET;
    logic [SCALE_W-1:0] mir_scale = POSITION_SCALE_RESET;

    motion_t   expected_motion[$];
    stim_row_t dir_rows[$];
    int        mismatches = 0;
    int        snd_idle_pct = 0;
    int        rcv_stall_pct = 0;
    logic      hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp48(input longint v);
        if (v > longint'(POS_MAX))
            return longint'(POS_MAX);
        if (v < longint'(POS_MIN))
            return longint'(POS_MIN);
        return v;
    endfunction

    function automatic motion_t predict_motion(input logic [15:0] c, input logic [31:0] t);
        motion_t m;
        longint  prev_c;
        longint  cur_c;
        longint  thr;
        longint  pos;
        longint  scaled;
        longint  divisor;
        longint  vel;
        prev_c = longint'({48'd0, mir_count});
        cur_c  = longint'({48'd0, c});
        thr    = longint'({48'd0, mir_thr});
        if (prev_c - cur_c > thr)
            mir_wraps = mir_wraps + 1;
        if (cur_c - prev_c > thr)
            mir_wraps = mir_wraps - 1;
        pos = clamp48(longint'(mir_wraps) * 64'sd65536 + cur_c);
        scaled = clamp48((pos * longint'({48'd0, mir_scale})) / 64'sd16384);
        // elapsed ticks wrap at 32 bits, so the divisor is at least one
        divisor = longint'({32'd0, t - mir_time}) + 64'sd1;
        vel = clamp48((pos - mir_pos) / divisor);
        mir_count = c;
        mir_time  = t;
        mir_pos   = pos;
        m.sp  = scaled[POS_W-1:0];
        m.vel = vel[POS_W-1:0];
        return m;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [31:0] a,
                                    input logic [31:0] b, input bit typed = 1'b0,
                                    input logic signed [POS_W-1:0] sp = '0,
                                    input logic signed [POS_W-1:0] vel = '0);
        stim_row_t r;
        r.kind  = kind;
        r.a     = a;
        r.b     = b;
        r.typed = typed;
        r.sp    = sp;
        r.vel   = vel;
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_sample(input logic [15:0] c, input logic [31:0] t,
                               input bit typed = 1'b0,
                               input logic signed [POS_W-1:0] sp = '0,
                               input logic signed [POS_W-1:0] vel = '0);
        motion_t m;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        count_sample <= c;
        sample_time  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        m = predict_motion(c, t);
        if (typed)
        begin
            m.sp  = sp;
            m.vel = vel;
        end
        expected_motion.push_back(m);
    endtask

    // Drop valid and let every outstanding result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_motion.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_WRAP_THRESHOLD)
            mir_thr = val;
        else if (idx == REG_POSITION_SCALE)
            mir_scale = val;
        @(posedge clk);
    endtask

    // Result side: random stall, plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    initial
    begin
        motion_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_motion.size() == 0)
                    report_mismatch($sformatf("unexpected result: scaled_position %0d velocity %0d",
                                              scaled_position, velocity));
                else
                begin
                    want = expected_motion.pop_front();
                    if (scaled_position !== want.sp)
                        report_mismatch($sformatf("scaled_position %0d, want %0d",
                                                  scaled_position, want.sp));
                    if (velocity !== want.vel)
                        report_mismatch($sformatf("velocity %0d, want %0d",
                                                  velocity, want.vel));
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("** quadrature_count_extender: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   r;
        logic [15:0] gen_c;
        logic [31:0] gen_t;
        logic [15:0] thr_v;
        logic [15:0] scale_v;
        int          sel;
        int          step;
        int          k;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        count_sample <= '0;
        sample_time  <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;

        // First sample after reset, downward wrap at full scale, and back up
        add_row(ROW_ITEM, 0, 0, 1'b1, '0, '0);
        add_row(ROW_ITEM, 32'hFFFF, 0, 1'b1, -48'sd1, -48'sd1);
        add_row(ROW_ITEM, 0, 0, 1'b1, '0, 48'sd1);
        // jumps of exactly the threshold do not wrap, one more does
        add_row(ROW_ITEM, 25000, 10);
        add_row(ROW_ITEM, 0, 9);
        add_row(ROW_ITEM, 25001, 32'hFFFF_FFFF);
        add_row(ROW_ITEM, 0, 0);
        add_row(ROW_CFG, 32'(REG_POSITION_SCALE), 0);
        add_row(ROW_ITEM, 40000, 100);
        add_row(ROW_CFG, 32'(REG_POSITION_SCALE), 32'hFFFF);
        add_row(ROW_ITEM, 32'hFFFF, 32'h8000_0000);
        add_row(ROW_ITEM, 32'h0001, 32'h7FFF_FFFF);
        add_row(ROW_CFG, 32'(REG_WRAP_THRESHOLD), 0);
        add_row(ROW_ITEM, 32'hFFFE, 32'h8000_0000);
        add_row(ROW_ITEM, 32'hFFFF, 32'h8000_0000);
        add_row(ROW_ITEM, 32'hFFFF, 32'h8000_0001);
        add_row(ROW_CFG, 32'(REG_WRAP_THRESHOLD), 32'hFFFF);
        add_row(ROW_ITEM, 0, 32'h0000_0003);
        add_row(ROW_ITEM, 32'hFFFF, 32'h0000_0004);
        add_row(ROW_ITEM, 32'hAAAA, 32'h5555_5555);
        add_row(ROW_ITEM, 32'h5555, 32'hAAAA_AAAA);
        add_row(ROW_CFG, 32'(REG_POSITION_SCALE), 19218);
        add_row(ROW_ITEM, 32'h8000, 32'hFFFF_FFFE);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(r.a[CFG_INDEX_W-1:0], r.b[15:0]);
            end
            else
                send_sample(r.a[15:0], r.b, r.typed, r.sp, r.vel);
        end

        gen_c = mir_count;
        gen_t = mir_time;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:       begin snd_idle_pct = 35; rcv_stall_pct = 51; end
                1:       begin snd_idle_pct = 51; rcv_stall_pct = 35; end
                default: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            endcase
            for (int sub = 0; sub < 2; sub++)
            begin
                k = ph * 2 + sub;
                case (k)
                    0:       begin thr_v = 16'd0;     scale_v = 16'hFFFF; end
                    1:       begin thr_v = 16'hFFFF;  scale_v = 16'd0;    end
                    2:       begin thr_v = 16'd25000; scale_v = 16'd19218; end
                    4:       begin thr_v = 16'd1;     scale_v = 16'd16384; end
                    default: begin thr_v = 16'($urandom); scale_v = 16'($urandom); end
                endcase
                wait_idle();
                write_reg(REG_WRAP_THRESHOLD, thr_v);
                write_reg(REG_POSITION_SCALE, scale_v);
                // fill the block behind a stalled result side
                if (ph == 2 && sub == 0)
                    hold_req <= 1'b1;
                for (int n = 0; n < RAND_PER_SET; n++)
                begin
                    if (ph == 0 && sub == 0 && n == RAND_PER_SET / 2)
                        wait_idle();
                    sel = $urandom_range(99);
                    if (sel < 70)
                    begin
                        // encoder motion: small steps, natural counter roll-over
                        step  = int'($urandom_range(6000)) - 3000;
                        gen_c = gen_c + 16'(step);
                        gen_t = gen_t + $urandom_range(3000);
                    end
                    else if (sel < 85)
                    begin
                        // jump right at the threshold
                        step = int'(mir_thr) + int'($urandom_range(2)) - 1;
                        if ($urandom_range(1) == 1)
                            step = -step;
                        gen_c = gen_c + 16'(step);
                        gen_t = gen_t + $urandom_range(50);
                    end
                    else
                    begin
                        gen_c = 16'($urandom);
                        gen_t = $urandom;
                    end
                    send_sample(gen_c, gen_t);
                end
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("** quadrature_count_extender: PASSED **");
        else
            $display("** quadrature_count_extender: FAILED **");
        $finish;
    end

endmodule
